### rtl/rpn_anchor_generator_core_defines.svh
// ----------------------------------------------------------------------------
// RPN anchor generator assertion macros
// Concurrent assertion wrappers clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RPN_ANCHOR_GENERATOR_CORE_DEFINES_SVH
`define RPN_ANCHOR_GENERATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define RPNAG_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rpn anchor generator: check failed");
// Next-cycle implication.
`define RPNAG_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rpn anchor generator: check failed");
`else
`define RPNAG_ASSERT_NOW(lbl, pre, post)
`define RPNAG_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

### rtl/rpnag_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN anchor generator package
// Shared widths, defaults, register indexes and width helpers.
// ----------------------------------------------------------------------------
package rpnag_pkg;

    localparam int MAX_SCALES_DEF = 4;
    localparam int FRAC_BITS_DEF  = 8;

    localparam int RATIO_W     = 13;
    localparam int BASE_W      = 9;
    localparam int COUNT_W     = 3;
    localparam int SCALE_W     = 16;
    localparam int COORD_W     = 28;
    localparam int SLOT_W      = 2;
    localparam int SLOT_REGS   = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int INDEX_W     = 3;

    localparam logic [INDEX_W-1:0] REG_BASE_SIZE   = 3'd0;
    localparam logic [INDEX_W-1:0] REG_SCALE_COUNT = 3'd1;
    localparam logic [INDEX_W-1:0] REG_SCALE_ZERO  = 3'd2;
    localparam logic [INDEX_W-1:0] REG_SCALE_ONE   = 3'd3;
    localparam logic [INDEX_W-1:0] REG_SCALE_TWO   = 3'd4;
    localparam logic [INDEX_W-1:0] REG_SCALE_THREE = 3'd5;

    // Width of the rounded root: search bits run from (F+1)/2+10 down to 0.
    function automatic int nw_width(input int frac);
        return (frac + 1) / 2 + 11;
    endfunction

    // Width of the rounded height nw * ratio.
    function automatic int nh_width(input int frac);
        return nw_width(frac) + RATIO_W + 1 - frac;
    endfunction

endpackage

### rtl/rpn_anchor_generator_core.sv
`timescale 1ns / 1ps
`include "rpn_anchor_generator_core_defines.svh"
// ----------------------------------------------------------------------------
// RPN anchor generator core
// Turns aspect ratio requests into scaled, centred anchor boxes.
// ----------------------------------------------------------------------------
// Usage: each request on the slave stream carries one aspect ratio (height
// over width, unsigned Q5.8). For every scale slot in use the master stream
// returns one box x0, y0, x1, y1 in signed fixed point with FRAC_BITS+1
// fractional bits; tuser is the scale slot and tlast marks the final box.
// The user writes the registers through cfg_wen, cfg_index and cfg_wdata
// only while the block is idle; the block itself does not enforce this.
// Unknown indexes are ignored. Each result bit of the anchor width search
// has a squaring register and then a ratio multiply and compare register;
// after them come the height register, the queue and the box stage
// registers (scale multiply, then centre, offset and clamp).
// Throughput: the back end emits one box per cycle while the receiver is
// ready, one for each scale slot in use; the front end takes a new request
// every cycle while the queue has room.
// Reset clears all valid state and loads the register defaults. When the
// receiver stalls, the output holds, the queue fills, and then the front
// pipeline freezes and drops tready.
// ----------------------------------------------------------------------------
module rpn_anchor_generator_core #(
    parameter int MAX_SCALES = rpnag_pkg::MAX_SCALES_DEF,
    parameter int FRAC_BITS  = rpnag_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Slave stream. tdata: aspect_ratio [12:0], zero padding [15:13].
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [15:0]                          s_tdata,
    // Master stream. tdata: left_edge [27:0], top_edge [55:28],
    // right_edge [83:56], bottom_edge [111:84]. tuser: scale_slot [1:0].
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [4*rpnag_pkg::COORD_W-1:0]      m_tdata,
    output logic                                 m_tlast,
    output logic [rpnag_pkg::SLOT_W-1:0]         m_tuser,
    // Register write port.
    input  logic                                 cfg_wen,
    input  logic [rpnag_pkg::INDEX_W-1:0]        cfg_index,
    input  logic [rpnag_pkg::SCALE_W-1:0]        cfg_wdata
);
    import rpnag_pkg::*;

    localparam int NW_W   = nw_width(FRAC_BITS);
    localparam int NH_W   = nh_width(FRAC_BITS);
    localparam int Q_W    = NW_W + NH_W;
    localparam int MS_CAP = (MAX_SCALES < SLOT_REGS) ? MAX_SCALES : SLOT_REGS;

    logic [BASE_W-1:0]  base_side_reg;
    logic [COUNT_W-1:0] scale_count_reg;
    logic [SCALE_W-1:0] scale_reg [SLOT_REGS];
    logic [COUNT_W-1:0] scale_limit;

    logic               fr_valid, q_ready, head_valid, pop;
    logic [NW_W-1:0]    fr_nw;
    logic [NH_W-1:0]    fr_nh;
    logic [Q_W-1:0]     head_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            base_side_reg   <= BASE_W'(16);
            scale_count_reg <= COUNT_W'(3);
            scale_reg[0]    <= SCALE_W'(2048);
            scale_reg[1]    <= SCALE_W'(4096);
            scale_reg[2]    <= SCALE_W'(8192);
            scale_reg[3]    <= SCALE_W'(16384);
        end else if (cfg_wen) begin
            case (cfg_index)
                REG_BASE_SIZE:   base_side_reg   <= cfg_wdata[BASE_W-1:0];
                REG_SCALE_COUNT: scale_count_reg <= cfg_wdata[COUNT_W-1:0];
                REG_SCALE_ZERO:  scale_reg[0]    <= cfg_wdata;
                REG_SCALE_ONE:   scale_reg[1]    <= cfg_wdata;
                REG_SCALE_TWO:   scale_reg[2]    <= cfg_wdata;
                REG_SCALE_THREE: scale_reg[3]    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Boxes per request: the slot count, capped by the available slots.
    assign scale_limit = (scale_count_reg > COUNT_W'(MS_CAP)) ? COUNT_W'(MS_CAP)
                                                               : scale_count_reg;

    rpnag_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .ratio     (s_tdata[RATIO_W-1:0]),
        .base_side (base_side_reg),
        .out_valid (fr_valid),
        .out_ready (q_ready),
        .out_nw    (fr_nw),
        .out_nh    (fr_nh)
    );

    rpnag_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (q_ready),
        .push_data  ({fr_nh, fr_nw}),
        .head_valid (head_valid),
        .pop        (pop),
        .head_data  (head_data)
    );

    rpnag_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .base_side   (base_side_reg),
        .scale_limit (scale_limit),
        .scales      (scale_reg),
        .head_valid  (head_valid),
        .head_nw     (head_data[NW_W-1:0]),
        .head_nh     (head_data[Q_W-1:NW_W]),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    // A sized request blocked at the queue must not vanish.
    `RPNAG_ASSERT_NEXT(a_front_hold, fr_valid && !q_ready, fr_valid)
    // The final box of a request carries the last slot in use.
    `RPNAG_ASSERT_NOW(a_last_slot, m_tvalid && m_tlast,
        (COUNT_W'(m_tuser) + COUNT_W'(1)) == scale_limit)
    // Any other box carries a slot below the last one.
    `RPNAG_ASSERT_NOW(a_mid_slot, m_tvalid && !m_tlast,
        (COUNT_W'(m_tuser) + COUNT_W'(1)) < scale_limit)

endmodule

### rtl/rpnag_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN anchor generator front end
// Pipelined bit search for the rounded anchor width, then the rounded height.
// ----------------------------------------------------------------------------
module rpnag_front #(
    parameter int FRAC_BITS = rpnag_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [rpnag_pkg::RATIO_W-1:0]         ratio,
    input  logic [rpnag_pkg::BASE_W-1:0]          base_side,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [rpnag_pkg::nw_width(FRAC_BITS)-1:0] out_nw,
    output logic [rpnag_pkg::nh_width(FRAC_BITS)-1:0] out_nh
);
    import rpnag_pkg::*;

    localparam int NW_W = nw_width(FRAC_BITS);
    localparam int NH_W = nh_width(FRAC_BITS);
    localparam int NB   = NW_W;
    localparam int O_W  = NW_W + 1;
    localparam int SQ_W = 2 * O_W;
    localparam int PR_W = SQ_W + RATIO_W;
    localparam int NS_W = NW_W + RATIO_W + 1;

    logic                 en;
    logic [RATIO_W-1:0]   r_fix;
    logic [2*BASE_W-1:0]  bsq;
    logic [PR_W-1:0]      lim;

    logic                 vs_reg [NB];
    logic                 vb_reg [NB];
    logic [SQ_W-1:0]      sq_reg [NB];
    logic [NW_W-1:0]      c_reg  [NB];
    logic [NW_W-1:0]      na_reg [NB];
    logic [RATIO_W-1:0]   ra_reg [NB];
    logic [NW_W-1:0]      nb_reg [NB];
    logic [RATIO_W-1:0]   rb_reg [NB];

    logic                 vf_reg;
    logic [NW_W-1:0]      nw_reg;
    logic [NH_W-1:0]      nh_reg;
    logic [NS_W-1:0]      nsum;

    // The whole pipeline moves together unless the finished item is blocked.
    assign en       = !vf_reg || out_ready;
    assign s_tready = en;
    assign r_fix    = (ratio == '0) ? RATIO_W'(1) : ratio;
    assign bsq      = (2*BASE_W)'(base_side) * (2*BASE_W)'(base_side);
    assign lim      = PR_W'(bsq) << (FRAC_BITS + 2);

    for (genvar j = 0; j < NB; j++) begin : g_bit
        logic               v_in;
        logic [NW_W-1:0]    n_in;
        logic [RATIO_W-1:0] r_in;
        logic [NW_W-1:0]    c;
        logic [O_W-1:0]     o;
        logic [SQ_W-1:0]    sq;
        logic [PR_W-1:0]    prod;

        if (j == 0) begin : g_first
            assign v_in = s_tvalid;
            assign n_in = '0;
            assign r_in = r_fix;
        end else begin : g_rest
            assign v_in = vb_reg[j-1];
            assign n_in = nb_reg[j-1];
            assign r_in = rb_reg[j-1];
        end

        // Trial candidate with this bit set; odd value 2c-1 squared.
        assign c    = n_in | (NW_W'(1) << (NB - 1 - j));
        assign o    = (O_W'(c) << 1) - O_W'(1);
        assign sq   = SQ_W'(o) * SQ_W'(o);
        assign prod = PR_W'(sq_reg[j]) * PR_W'(ra_reg[j]);

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                vs_reg[j] <= 1'b0;
                vb_reg[j] <= 1'b0;
            end else if (en) begin
                vs_reg[j] <= v_in;
                vb_reg[j] <= vs_reg[j];
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                sq_reg[j] <= sq;
                c_reg[j]  <= c;
                na_reg[j] <= n_in;
                ra_reg[j] <= r_in;
                nb_reg[j] <= (prod <= lim) ? c_reg[j] : na_reg[j];
                rb_reg[j] <= ra_reg[j];
            end
        end
    end

    // Height is the width times the ratio, rounded half up.
    assign nsum = NS_W'(nb_reg[NB-1]) * NS_W'(rb_reg[NB-1])
                + (NS_W'(1) << (FRAC_BITS - 1));

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vf_reg <= 1'b0;
        end else if (en) begin
            vf_reg <= vb_reg[NB-1];
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            nw_reg <= nb_reg[NB-1];
            nh_reg <= nsum[NS_W-1:FRAC_BITS];
        end
    end

    assign out_valid = vf_reg;
    assign out_nw    = nw_reg;
    assign out_nh    = nh_reg;

endmodule

### rtl/rpnag_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN anchor generator queue
// Small register FIFO holding anchor sizes between front and back end.
// ----------------------------------------------------------------------------
module rpnag_queue #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             head_valid,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data
);
    import rpnag_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             push, take;

    assign push_ready = (count_reg != (PTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign take       = pop && head_valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = take ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(take);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/rpnag_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN anchor generator back end
// Issues one box per scale slot: scale multiply, then centre, offset, clamp.
// ----------------------------------------------------------------------------
module rpnag_back #(
    parameter int FRAC_BITS = rpnag_pkg::FRAC_BITS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic [rpnag_pkg::BASE_W-1:0]              base_side,
    input  logic [rpnag_pkg::COUNT_W-1:0]             scale_limit,
    input  logic [rpnag_pkg::SCALE_W-1:0]             scales [rpnag_pkg::SLOT_REGS],
    input  logic                                      head_valid,
    input  logic [rpnag_pkg::nw_width(FRAC_BITS)-1:0] head_nw,
    input  logic [rpnag_pkg::nh_width(FRAC_BITS)-1:0] head_nh,
    output logic                                      pop,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [4*rpnag_pkg::COORD_W-1:0]           m_tdata,
    output logic                                      m_tlast,
    output logic [rpnag_pkg::SLOT_W-1:0]              m_tuser
);
    import rpnag_pkg::*;

    localparam int NW_W  = nw_width(FRAC_BITS);
    localparam int NH_W  = nh_width(FRAC_BITS);
    localparam int HW_W  = NW_W + SCALE_W;
    localparam int HH_W  = NH_W + SCALE_W;
    localparam int SUM_W = ((HW_W > HH_W) ? HW_W : HH_W) + 2;

    localparam logic signed [SUM_W-1:0] SAT_HI =
        signed'({{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] SAT_LO =
        signed'({{(SUM_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}});

    function automatic logic [COORD_W-1:0] sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] t;
        t = v;
        if (v > SAT_HI) t = SAT_HI;
        if (v < SAT_LO) t = SAT_LO;
        return t[COORD_W-1:0];
    endfunction

    logic [SLOT_W-1:0]   k_reg, k_next;
    logic                last_k, issue, en_a, en_b;
    logic                va_reg;
    logic [HW_W-1:0]     hw_reg;
    logic [HH_W-1:0]     hh_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic                lasta_reg;
    logic                vb_reg;
    logic [COORD_W-1:0]  x0_reg, y0_reg, x1_reg, y1_reg;
    logic [SLOT_W-1:0]   slotb_reg;
    logic                lastb_reg;
    logic signed [SUM_W-1:0] c2, one, hw_s, hh_s;

    assign last_k = ((COUNT_W'(k_reg) + COUNT_W'(1)) == scale_limit);
    assign en_b   = !vb_reg || m_tready;
    assign en_a   = !va_reg || en_b;
    assign issue  = head_valid && en_a && (scale_limit != '0);
    assign pop    = head_valid && ((scale_limit == '0) || (en_a && last_k));

    always_comb begin
        k_next = k_reg;
        if (pop) begin
            k_next = '0;
        end else if (issue) begin
            k_next = k_reg + SLOT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            k_reg  <= '0;
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            k_reg <= k_next;
            if (en_a) begin
                va_reg <= issue;
            end
            if (en_b) begin
                vb_reg <= va_reg;
            end
        end
    end

    assign c2   = signed'(SUM_W'(base_side) << FRAC_BITS);
    assign one  = signed'(SUM_W'(1) << (FRAC_BITS + 1));
    assign hw_s = signed'(SUM_W'(hw_reg));
    assign hh_s = signed'(SUM_W'(hh_reg));

    always_ff @(posedge clk) begin
        if (en_a) begin
            hw_reg    <= HW_W'(head_nw) * HW_W'(scales[k_reg]);
            hh_reg    <= HH_W'(head_nh) * HH_W'(scales[k_reg]);
            slot_reg  <= k_reg;
            lasta_reg <= last_k;
        end
        if (en_b) begin
            x0_reg    <= sat(c2 - hw_s);
            y0_reg    <= sat(c2 - hh_s);
            x1_reg    <= sat(c2 + hw_s - one);
            y1_reg    <= sat(c2 + hh_s - one);
            slotb_reg <= slot_reg;
            lastb_reg <= lasta_reg;
        end
    end

    assign m_tvalid = vb_reg;
    assign m_tdata  = {y1_reg, x1_reg, y0_reg, x0_reg};
    assign m_tlast  = lastb_reg;
    assign m_tuser  = slotb_reg;

endmodule
